// ----- sv/assert_macros.svh -----
// assertion macros used by the checker file
// no dependencies; include once per compilation unit
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is high
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is high
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ----- sv/vfv_pkg.sv -----
// shared types, constants and helpers of the voxel face visibility unit
// no dependencies
package vfv_pkg;

  localparam int unsigned SIZE_X_DEF = 32;
  localparam int unsigned SIZE_Y_DEF = 32;
  localparam int unsigned SIZE_Z_DEF = 32;

  localparam int unsigned COORD_W = 5;
  localparam int unsigned LIM_W   = 9;
  localparam int unsigned FACES   = 6;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [1:0]         code_t;
  typedef logic [2:0]         face_t;
  typedef logic [FACES-1:0]   mask_t;

  localparam code_t CODE_AIR   = 2'd0;
  localparam code_t CODE_OPAQUE = 2'd1;
  localparam code_t CODE_CLEAR = 2'd2;
  localparam code_t CODE_DIRT  = 2'd3;

  localparam face_t FACE_NX = 3'd0;
  localparam face_t FACE_NY = 3'd1;
  localparam face_t FACE_NZ = 3'd2;
  localparam face_t FACE_PX = 3'd3;
  localparam face_t FACE_PY = 3'd4;
  localparam face_t FACE_PZ = 3'd5;

  localparam logic KIND_WRITE = 1'b0;
  localparam logic KIND_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WRITE,
    ST_SELF,
    ST_FACE,
    ST_TAIL,
    ST_DONE
  } state_t;

  // status seen by the sequencer
  typedef struct packed {
    logic req_valid;
    logic req_write;
    logic req_in_grid;
    logic out_free;
  } seq_stat_t;

  // controls driven by the sequencer
  typedef struct packed {
    logic  req_ready;
    logic  mem_we_clear;
    logic  mem_we_item;
    logic  mem_re_self;
    logic  mem_re_face;
    logic  load_out;
    face_t step;
  } seq_ctrl_t;

  // face toward an in-grid neighbour is open
  function automatic logic face_open(code_t neigh, logic self_clear);
    return (neigh == CODE_AIR) || ((neigh == CODE_CLEAR) && !self_clear);
  endfunction

endpackage

// ----- sv/vfv_if.sv -----
// request and response channel interfaces of the voxel face visibility unit
// depends on vfv_pkg
interface vfv_req_if;
  logic           valid;
  logic           ready;
  logic           kind;
  vfv_pkg::coord_t pos_x;
  vfv_pkg::coord_t pos_y;
  vfv_pkg::coord_t pos_z;
  vfv_pkg::code_t  voxel_code;

  modport source (output valid, kind, pos_x, pos_y, pos_z, voxel_code, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, voxel_code, output ready);
endinterface

interface vfv_rsp_if;
  logic           valid;
  logic           ready;
  logic           present;
  vfv_pkg::mask_t face_mask;
  logic           is_clear;
  logic           to_grass;

  modport source (output valid, present, face_mask, is_clear, to_grass, input ready);
  modport sink   (input valid, present, face_mask, is_clear, to_grass, output ready);
endinterface

// ----- sv/vfv_store.sv -----
// single-port voxel code memory with registered read data
// depends on vfv_pkg
module vfv_store #(
  parameter int unsigned DEPTH = vfv_pkg::SIZE_X_DEF * vfv_pkg::SIZE_Y_DEF * vfv_pkg::SIZE_Z_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic           clk,
  input  logic           we,
  input  logic           re,
  input  logic [AW-1:0]  addr,
  input  vfv_pkg::code_t wdata,
  output vfv_pkg::code_t rdata
);

  vfv_pkg::code_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end else if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- sv/vfv_agu.sv -----
// shared neighbour address unit: base plus or minus the stride of one axis
// depends on vfv_pkg
module vfv_agu #(
  parameter int unsigned SIZE_X = vfv_pkg::SIZE_X_DEF,
  parameter int unsigned SIZE_Y = vfv_pkg::SIZE_Y_DEF,
  parameter int unsigned AW     = 15
) (
  input  logic [AW-1:0]  base,
  input  vfv_pkg::face_t face,
  output logic [AW-1:0]  addr
);

  localparam int unsigned STRIDE_Y = SIZE_X;
  localparam int unsigned STRIDE_Z = SIZE_X * SIZE_Y;

  logic [AW-1:0] off;

  always_comb begin
    case (face) inside
      vfv_pkg::FACE_NX, vfv_pkg::FACE_PX: off = AW'(1);
      vfv_pkg::FACE_NY, vfv_pkg::FACE_PY: off = AW'(STRIDE_Y);
      default:                            off = AW'(STRIDE_Z);
    endcase
    // minus faces come first in the face order
    addr = (face < vfv_pkg::FACE_PX) ? (base - off) : (base + off);
  end

endmodule

// ----- sv/vfv_seq.sv -----
// sequencer: clearing pass, item steps and neighbour step counter
// depends on vfv_pkg
module vfv_seq #(
  parameter int unsigned DEPTH = vfv_pkg::SIZE_X_DEF * vfv_pkg::SIZE_Y_DEF * vfv_pkg::SIZE_Z_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic               clk,
  input  logic               rst,
  input  vfv_pkg::seq_stat_t stat,
  output vfv_pkg::seq_ctrl_t ctrl,
  output logic [AW-1:0]      clr_addr
);

  vfv_pkg::state_t state, state_next;
  vfv_pkg::face_t  step, step_next;
  logic [AW-1:0]   clr_cnt, clr_cnt_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= vfv_pkg::ST_CLEAR;
      step    <= vfv_pkg::FACE_NX;
      clr_cnt <= '0;
    end else begin
      state   <= state_next;
      step    <= step_next;
      clr_cnt <= clr_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    step_next    = step;
    clr_cnt_next = clr_cnt;
    unique case (state)
      vfv_pkg::ST_CLEAR: begin
        clr_cnt_next = clr_cnt + AW'(1);
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = vfv_pkg::ST_IDLE;
        end
      end
      vfv_pkg::ST_IDLE: begin
        if (stat.req_valid) begin
          if (!stat.req_in_grid) begin
            state_next = vfv_pkg::ST_DONE;
          end else if (stat.req_write) begin
            state_next = vfv_pkg::ST_WRITE;
          end else begin
            state_next = vfv_pkg::ST_SELF;
          end
        end
      end
      vfv_pkg::ST_WRITE: state_next = vfv_pkg::ST_DONE;
      vfv_pkg::ST_SELF: begin
        state_next = vfv_pkg::ST_FACE;
        step_next  = vfv_pkg::FACE_NX;
      end
      vfv_pkg::ST_FACE: begin
        if (step == vfv_pkg::FACE_PZ) begin
          state_next = vfv_pkg::ST_TAIL;
          step_next  = vfv_pkg::FACE_NX;
        end else begin
          step_next = step + 3'd1;
        end
      end
      vfv_pkg::ST_TAIL: state_next = vfv_pkg::ST_DONE;
      vfv_pkg::ST_DONE: begin
        if (stat.out_free) begin
          state_next = vfv_pkg::ST_IDLE;
        end
      end
      default: state_next = vfv_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl              = '0;
    ctrl.step         = step;
    ctrl.req_ready    = (state == vfv_pkg::ST_IDLE);
    ctrl.mem_we_clear = (state == vfv_pkg::ST_CLEAR);
    ctrl.mem_we_item  = (state == vfv_pkg::ST_WRITE);
    ctrl.mem_re_self  = (state == vfv_pkg::ST_SELF);
    ctrl.mem_re_face  = (state == vfv_pkg::ST_FACE);
    ctrl.load_out     = (state == vfv_pkg::ST_DONE) && stat.out_free;
  end

  assign clr_addr = clr_cnt;

endmodule

// ----- sv/voxel_face_visibility_unit.sv -----
// query: from accept to result valid, a self read, up to six neighbour reads through one
//   single-port memory, one evaluate and one result load; write: the write step and
//   the result load; off-grid: the result load alone, which waits while the output is full
// one item at a time, set by the single memory port with up to 7 reads per query; the
//   next item is taken while the previous result still waits in the output register
// rst synchronous: a clearing pass then sets all SIZE_X*SIZE_Y*SIZE_Z cells to air
module voxel_face_visibility_unit #(
  parameter int unsigned SIZE_X = vfv_pkg::SIZE_X_DEF,
  parameter int unsigned SIZE_Y = vfv_pkg::SIZE_Y_DEF,
  parameter int unsigned SIZE_Z = vfv_pkg::SIZE_Z_DEF
) (
  input logic       clk,
  input logic       rst,
  vfv_req_if.sink   req,
  vfv_rsp_if.source rsp
);

  // clearing pass covers 32768 addresses at default size, request ready stays low during it
  localparam int unsigned DEPTH    = SIZE_X * SIZE_Y * SIZE_Z;
  localparam int unsigned AW       = $clog2(DEPTH);
  localparam int unsigned STRIDE_Y = SIZE_X;
  localparam int unsigned STRIDE_Z = SIZE_X * SIZE_Y;
  localparam int unsigned LW       = vfv_pkg::LIM_W;

  vfv_pkg::seq_stat_t stat;
  vfv_pkg::seq_ctrl_t ctrl;
  logic [AW-1:0]      clr_addr;

  // item operands captured at accept
  logic                 accept;
  logic [AW-1:0]        base, base_next;
  vfv_pkg::code_t       code_r;
  vfv_pkg::mask_t       nb_ok, nb_ok_next;
  logic                 in_grid_next;
  logic [LW-1:0]        xw, yw, zw;

  // memory side
  logic [AW-1:0]  agu_addr;
  logic [AW-1:0]  mem_addr;
  logic           mem_we, mem_re;
  vfv_pkg::code_t mem_wdata, mem_rdata;

  // evaluation of returning read data
  logic           pend_self, pend_face;
  vfv_pkg::face_t pend_idx;
  vfv_pkg::code_t self_code;
  vfv_pkg::mask_t mask;
  logic           above_air;
  logic           self_clear;

  // output register
  logic out_valid;

  assign accept = req.valid && ctrl.req_ready;

  // coordinate checks against the grid limits, widened to hold the limits
  always_comb begin
    xw = {{(LW - vfv_pkg::COORD_W){1'b0}}, req.pos_x};
    yw = {{(LW - vfv_pkg::COORD_W){1'b0}}, req.pos_y};
    zw = {{(LW - vfv_pkg::COORD_W){1'b0}}, req.pos_z};
    in_grid_next = (xw < LW'(SIZE_X)) && (yw < LW'(SIZE_Y)) && (zw < LW'(SIZE_Z));
    nb_ok_next[vfv_pkg::FACE_NX] = (req.pos_x != '0);
    nb_ok_next[vfv_pkg::FACE_NY] = (req.pos_y != '0);
    nb_ok_next[vfv_pkg::FACE_NZ] = (req.pos_z != '0);
    nb_ok_next[vfv_pkg::FACE_PX] = (xw + LW'(1)) < LW'(SIZE_X);
    nb_ok_next[vfv_pkg::FACE_PY] = (yw + LW'(1)) < LW'(SIZE_Y);
    nb_ok_next[vfv_pkg::FACE_PZ] = (zw + LW'(1)) < LW'(SIZE_Z);
    // linear address, x fastest; only meaningful inside the grid
    base_next = AW'(32'(req.pos_x) + 32'(req.pos_y) * STRIDE_Y
                    + 32'(req.pos_z) * STRIDE_Z);
  end

  always_comb begin
    stat             = '0;
    stat.req_valid   = req.valid;
    stat.req_write   = (req.kind == vfv_pkg::KIND_WRITE);
    stat.req_in_grid = in_grid_next;
    stat.out_free    = !out_valid || rsp.ready;
  end

  vfv_seq #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_seq (
    .clk      (clk),
    .rst      (rst),
    .stat     (stat),
    .ctrl     (ctrl),
    .clr_addr (clr_addr)
  );

  vfv_agu #(
    .SIZE_X (SIZE_X),
    .SIZE_Y (SIZE_Y),
    .AW     (AW)
  ) u_agu (
    .base (base),
    .face (ctrl.step),
    .addr (agu_addr)
  );

  // one port: clear pass, item write, self read or neighbour read
  always_comb begin
    if (ctrl.mem_we_clear) begin
      mem_addr = clr_addr;
    end else if (ctrl.mem_re_face) begin
      mem_addr = agu_addr;
    end else begin
      mem_addr = base;
    end
    mem_we    = ctrl.mem_we_clear || ctrl.mem_we_item;
    mem_wdata = ctrl.mem_we_clear ? vfv_pkg::CODE_AIR : code_r;
    // neighbours outside the grid are not read, their face stays closed
    mem_re    = ctrl.mem_re_self || (ctrl.mem_re_face && nb_ok[ctrl.step]);
  end

  vfv_store #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // read data arrives in the cycle after its read, tagged by the pend registers
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_self <= 1'b0;
      pend_face <= 1'b0;
    end else begin
      pend_self <= ctrl.mem_re_self;
      pend_face <= ctrl.mem_re_face;
    end
  end

  assign self_clear = (self_code == vfv_pkg::CODE_CLEAR);

  always_ff @(posedge clk) begin
    pend_idx <= ctrl.step;
    if (accept) begin
      base      <= base_next;
      code_r    <= req.voxel_code;
      nb_ok     <= nb_ok_next;
      // air until the self read lands, so writes and off-grid items answer zero
      self_code <= vfv_pkg::CODE_AIR;
      mask      <= '0;
      above_air <= 1'b0;
    end else begin
      if (pend_self) begin
        self_code <= mem_rdata;
      end
      if (pend_face) begin
        mask[pend_idx] <= nb_ok[pend_idx] && vfv_pkg::face_open(mem_rdata, self_clear);
        if (pend_idx == vfv_pkg::FACE_PZ) begin
          above_air <= nb_ok[vfv_pkg::FACE_PZ] && (mem_rdata == vfv_pkg::CODE_AIR);
        end
      end
    end
  end

  // result register, parts the item side from the response side
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctrl.load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_out) begin
      rsp.present   <= (self_code != vfv_pkg::CODE_AIR);
      rsp.face_mask <= (self_code != vfv_pkg::CODE_AIR) ? mask : '0;
      rsp.is_clear  <= self_clear;
      rsp.to_grass  <= (self_code == vfv_pkg::CODE_DIRT) && above_air;
    end
  end

  assign rsp.valid = out_valid;
  assign req.ready = ctrl.req_ready;

endmodule

// ----- sv/vfv_checker.sv -----
// port-level checks of the voxel face visibility unit, bound to the top level
// depends on vfv_pkg and assert_macros.svh
`include "assert_macros.svh"

module vfv_checker (
  input logic           clk,
  input logic           rst,
  input logic           req_valid,
  input logic           req_ready,
  input logic           rsp_valid,
  input logic           rsp_ready,
  input logic           present,
  input vfv_pkg::mask_t face_mask,
  input logic           is_clear,
  input logic           to_grass
);

  // a stalled result beat stays and holds its face mask and present flag
  `ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready, rsp_valid)
  `ASSERT_NEXT(a_rsp_stable, clk, rst, rsp_valid && !rsp_ready, $stable(face_mask) && $stable(present))

  // one item at a time: busy right after an accept
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, req_valid && req_ready, !req_ready)

  // air, writes and off-grid items answer all zero
  `ASSERT_IMPLY(a_absent_zero, clk, rst, rsp_valid && !present, face_mask == '0 && !is_clear && !to_grass)

  // grass only on a present voxel, never on a transparent one
  `ASSERT_IMPLY(a_grass_dirt, clk, rst, rsp_valid && to_grass, present && !is_clear)

endmodule

bind voxel_face_visibility_unit vfv_checker u_vfv_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .present   (rsp.present),
  .face_mask (rsp.face_mask),
  .is_clear  (rsp.is_clear),
  .to_grass  (rsp.to_grass)
);
